// ===== rtl/wqa_pkg.sv =====
package wqa_pkg;

   // field widths
   localparam int TEMP_W = 15;
   localparam int PH_W   = 11;
   localparam int BAND_W = 9;
   localparam int TDS_W  = 16;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // band math widths: ph limits plus three band steps need one more bit
   localparam int EDGE_W  = PH_W + 1;
   localparam int LHS_W   = 30;
   localparam int SLOPE_W = 13;
   localparam int PROD_W  = 28;
   localparam int CMP_W   = 32;

   // register reset values
   localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = 15'sd1500;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = 15'sd3000;
   localparam logic [PH_W-1:0]          PH_LOW_RST    = 11'd650;
   localparam logic [PH_W-1:0]          PH_HIGH_RST   = 11'd850;
   localparam logic [BAND_W-1:0]        BAND_RST      = 9'd50;
   localparam logic [TDS_W-1:0]         TDS_DEF_RST   = 16'd1000;

   // tds limit lines, scaled by 10000: 10000*d > icpt - slope*t
   localparam logic [LHS_W-1:0]          TDS_SCALE     = 30'd10000;
   localparam logic signed [SLOPE_W-1:0] SLOPE_SHALLOW = 13'sd1667;
   localparam logic signed [SLOPE_W-1:0] SLOPE_STEEP   = 13'sd3333;
   localparam logic signed [CMP_W-1:0]   ICPT_A        = 32'sd13000000;
   localparam logic signed [CMP_W-1:0]   ICPT_B        = 32'sd15750000;
   localparam logic signed [CMP_W-1:0]   ICPT_C        = 32'sd9500000;

   // event codes
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_LOW  = 2'd1;
   localparam logic [1:0] EV_HIGH = 2'd2;

   // register map, word index
   typedef enum logic [2:0] {
      REG_TEMP_LOW  = 3'd0,
      REG_TEMP_HIGH = 3'd1,
      REG_PH_LOW    = 3'd2,
      REG_PH_HIGH   = 3'd3,
      REG_PH_BAND   = 3'd4,
      REG_TDS_DEF   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_low_limit;
      logic signed [TEMP_W-1:0] temp_high_limit;
      logic [PH_W-1:0]          ph_low_limit;
      logic [PH_W-1:0]          ph_high_limit;
      logic [BAND_W-1:0]        ph_band_width;
      logic [TDS_W-1:0]         tds_default_limit;
   } cfg_type;

   typedef struct packed {
      logic temp_alert;
      logic temp_low;
      logic ph_alert;
      logic ph_low;
      logic tds_alert;
   } alert_type;

endpackage

// ===== rtl/wqa_eval.sv =====
module wqa_eval (
   input  wqa_pkg::cfg_type                      cfg,
   input  logic signed [wqa_pkg::TEMP_W-1:0]     temp,
   input  logic [wqa_pkg::PH_W-1:0]              ph,
   input  logic [wqa_pkg::TDS_W-1:0]             tds,
   output wqa_pkg::alert_type                    alert
);
   import wqa_pkg::*;

   logic                       t_low, t_alert, p_low, p_alert;
   logic [EDGE_W-1:0]          ph_ext, low_ext, high_ext, edge1, edge3;
   logic                       in_a, in_b, in_c, in_band;
   logic signed [SLOPE_W-1:0]  slope_sel;
   logic signed [CMP_W-1:0]    icpt_sel;
   logic signed [PROD_W-1:0]   slope_prod;
   logic [LHS_W-1:0]           lhs_mag;
   logic signed [CMP_W-1:0]    lhs, rhs;
   logic                       over_line;

   // range checks on temperature and ph
   assign t_low   = temp < cfg.temp_low_limit;
   assign t_alert = t_low || (temp > cfg.temp_high_limit);
   assign p_low   = ph < cfg.ph_low_limit;
   assign p_alert = p_low || (ph > cfg.ph_high_limit);

   // band edges at low+w and low+3w
   assign ph_ext   = EDGE_W'(ph);
   assign low_ext  = EDGE_W'(cfg.ph_low_limit);
   assign high_ext = EDGE_W'(cfg.ph_high_limit);
   assign edge1    = low_ext + EDGE_W'(cfg.ph_band_width);
   assign edge3    = low_ext + EDGE_W'(cfg.ph_band_width)
                   + EDGE_W'({cfg.ph_band_width, 1'b0});

   assign in_a    = (ph_ext >= low_ext) && (ph_ext < edge1);
   assign in_b    = (ph_ext >= edge1) && (ph_ext < edge3);
   assign in_c    = (ph_ext >= edge3) && (ph_ext <= high_ext);
   assign in_band = in_a || in_b || in_c;

   // later band wins where bands overlap
   always_comb begin
      if (in_c) begin
         slope_sel = SLOPE_SHALLOW;
         icpt_sel  = ICPT_C;
      end else if (in_b) begin
         slope_sel = SLOPE_STEEP;
         icpt_sel  = ICPT_B;
      end else begin
         slope_sel = SLOPE_SHALLOW;
         icpt_sel  = ICPT_A;
      end
   end

   // exact line compare: 10000*tds > icpt - slope*temp
   assign slope_prod = PROD_W'(slope_sel) * PROD_W'(temp);
   assign lhs_mag    = LHS_W'(tds) * TDS_SCALE;
   assign lhs        = signed'({{(CMP_W-LHS_W){1'b0}}, lhs_mag});
   assign rhs        = icpt_sel - CMP_W'(slope_prod);
   assign over_line  = lhs > rhs;

   assign alert.temp_alert = t_alert;
   assign alert.temp_low   = t_low;
   assign alert.ph_alert   = p_alert;
   assign alert.ph_low     = p_low;
   assign alert.tds_alert  = (!t_alert && in_band) ? over_line
                                                   : (tds > cfg.tds_default_limit);

endmodule

// ===== rtl/water_quality_alarm_unit.sv =====
// Water quality alarm. Each sample transfer (temperature, pH, TDS, button) gives exactly one
// result transfer with the three alert levels, the button copy and rising-edge event codes.
// Samples pass through an input register and a result register, so one sample can be taken
// every cycle. A result is offered once it moves into the result register and can transfer at
// the next edge at the earliest. A held result stalls the result register, and once the input
// register is also full, rsp_ready low stalls the sample channel. The TDS limit inside the
// temperature range is a line in temperature picked by pH band, compared exactly in integers.
// Limits live in six APB registers at byte offsets 0x00 to 0x14 and should be written only
// while no sample is in flight.
module water_quality_alarm_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [wqa_pkg::TEMP_W-1:0]     req_temperature_reading,
   input  logic [wqa_pkg::PH_W-1:0]              req_ph_reading,
   input  logic [wqa_pkg::TDS_W-1:0]             req_tds_reading,
   input  logic                                  req_button_level,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_temp_alert,
   output logic                                  rsp_ph_alert,
   output logic                                  rsp_tds_alert,
   output logic                                  rsp_button_out,
   output logic [1:0]                            rsp_temp_event,
   output logic [1:0]                            rsp_ph_event,
   output logic                                  rsp_tds_event,
   // configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [wqa_pkg::ADDR_W-1:0]            paddr,
   input  logic [wqa_pkg::DATA_W-1:0]            pwdata,
   output logic [wqa_pkg::DATA_W-1:0]            prdata,
   output logic                                  pready
);
   import wqa_pkg::*;

   cfg_type                  cfg_ff, cfg_in;
   reg_index_type            reg_sel;
   logic                     cfg_wr;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [TEMP_W-1:0] s1_temp_ff;
   logic [PH_W-1:0]          s1_ph_ff;
   logic [TDS_W-1:0]         s1_tds_ff;
   logic                     s1_button_ff;

   logic                     out_valid_ff, out_valid_in;
   logic                     out_temp_alert_ff, out_ph_alert_ff, out_tds_alert_ff;
   logic                     out_button_ff, out_tds_event_ff;
   logic [1:0]               out_temp_event_ff, out_ph_event_ff;
   logic [1:0]               temp_event_in, ph_event_in;

   logic                     prev_temp_ff, prev_ph_ff, prev_tds_ff;

   logic                     req_xfer, out_free, s1_adv;
   alert_type                alert;

   // register write and read decode
   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[ADDR_W-1:2]);
   assign cfg_wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (reg_sel)
            REG_TEMP_LOW:  cfg_in.temp_low_limit    = signed'(pwdata[TEMP_W-1:0]);
            REG_TEMP_HIGH: cfg_in.temp_high_limit   = signed'(pwdata[TEMP_W-1:0]);
            REG_PH_LOW:    cfg_in.ph_low_limit      = pwdata[PH_W-1:0];
            REG_PH_HIGH:   cfg_in.ph_high_limit     = pwdata[PH_W-1:0];
            REG_PH_BAND:   cfg_in.ph_band_width     = pwdata[BAND_W-1:0];
            REG_TDS_DEF:   cfg_in.tds_default_limit = pwdata[TDS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TEMP_LOW:  prdata = {{(DATA_W-TEMP_W){cfg_ff.temp_low_limit[TEMP_W-1]}},
                                  cfg_ff.temp_low_limit};
         REG_TEMP_HIGH: prdata = {{(DATA_W-TEMP_W){cfg_ff.temp_high_limit[TEMP_W-1]}},
                                  cfg_ff.temp_high_limit};
         REG_PH_LOW:    prdata = DATA_W'(cfg_ff.ph_low_limit);
         REG_PH_HIGH:   prdata = DATA_W'(cfg_ff.ph_high_limit);
         REG_PH_BAND:   prdata = DATA_W'(cfg_ff.ph_band_width);
         REG_TDS_DEF:   prdata = DATA_W'(cfg_ff.tds_default_limit);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_low_limit    <= TEMP_LOW_RST;
         cfg_ff.temp_high_limit   <= TEMP_HIGH_RST;
         cfg_ff.ph_low_limit      <= PH_LOW_RST;
         cfg_ff.ph_high_limit     <= PH_HIGH_RST;
         cfg_ff.ph_band_width     <= BAND_RST;
         cfg_ff.tds_default_limit <= TDS_DEF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline flow control
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_xfer  = req_valid && req_ready;

   assign s1_valid_in  = req_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // alert evaluation on the registered sample
   wqa_eval u_eval (
      .cfg   (cfg_ff),
      .temp  (s1_temp_ff),
      .ph    (s1_ph_ff),
      .tds   (s1_tds_ff),
      .alert (alert)
   );

   // rising-edge event codes against the previous sample
   always_comb begin
      temp_event_in = EV_NONE;
      if (alert.temp_alert && !prev_temp_ff) begin
         temp_event_in = alert.temp_low ? EV_LOW : EV_HIGH;
      end
      ph_event_in = EV_NONE;
      if (alert.ph_alert && !prev_ph_ff) begin
         ph_event_in = alert.ph_low ? EV_LOW : EV_HIGH;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_temp_ff <= 1'b0;
         prev_ph_ff   <= 1'b0;
         prev_tds_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            prev_temp_ff <= alert.temp_alert;
            prev_ph_ff   <= alert.ph_alert;
            prev_tds_ff  <= alert.tds_alert;
         end
      end
   end

   // sample and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_temp_ff   <= req_temperature_reading;
         s1_ph_ff     <= req_ph_reading;
         s1_tds_ff    <= req_tds_reading;
         s1_button_ff <= req_button_level;
      end
      if (s1_adv) begin
         out_temp_alert_ff <= alert.temp_alert;
         out_ph_alert_ff   <= alert.ph_alert;
         out_tds_alert_ff  <= alert.tds_alert;
         out_button_ff     <= s1_button_ff;
         out_temp_event_ff <= temp_event_in;
         out_ph_event_ff   <= ph_event_in;
         out_tds_event_ff  <= alert.tds_alert && !prev_tds_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_temp_alert = out_temp_alert_ff;
   assign rsp_ph_alert   = out_ph_alert_ff;
   assign rsp_tds_alert  = out_tds_alert_ff;
   assign rsp_button_out = out_button_ff;
   assign rsp_temp_event = out_temp_event_ff;
   assign rsp_ph_event   = out_ph_event_ff;
   assign rsp_tds_event  = out_tds_event_ff;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wqa_pkg::*;

   // one water sample as offered on the sample channel
   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic [PH_W-1:0]          ph;
      logic [TDS_W-1:0]         tds;
      logic                     button;
   } sample_type;

   // alarm verdict for one sample, in result port order
   typedef struct packed {
      logic       temp_alert;
      logic       ph_alert;
      logic       tds_alert;
      logic       button_out;
      logic [1:0] temp_event;
      logic [1:0] ph_event;
      logic       tds_event;
   } verdict_type;

   // tds lines, scaled by 10000
   localparam longint LINE_SCALE     = 10000;
   localparam longint SHALLOW_SLOPE  = 1667;
   localparam longint STEEP_SLOPE    = 3333;
   localparam longint BAND_A_ICPT    = 13000000;
   localparam longint BAND_B_ICPT    = 15750000;
   localparam longint BAND_C_ICPT    = 9500000;
   localparam int     HOLD_OFF_LONG  = 60;
   localparam int     DRAIN_LIMIT    = 40000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [TEMP_W-1:0] req_temperature_reading = '0;
   logic [PH_W-1:0]          req_ph_reading = '0;
   logic [TDS_W-1:0]         req_tds_reading = '0;
   logic                     req_button_level = 1'b0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_temp_alert;
   logic       rsp_ph_alert;
   logic       rsp_tds_alert;
   logic       rsp_button_out;
   logic [1:0] rsp_temp_event;
   logic [1:0] rsp_ph_event;
   logic       rsp_tds_event;

   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // alarm limits as currently programmed, and alert history
   cfg_type limits;
   logic    last_temp_alert = 1'b0;
   logic    last_ph_alert = 1'b0;
   logic    last_tds_alert = 1'b0;

   sample_type  pending_samples[$];
   verdict_type expected_verdicts[$];
   sample_type  offered;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_off_cycles = 0;
   bit          calm = 1'b0;
   int          fail_count = 0;
   int          result_count = 0;

   water_quality_alarm_unit u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_temperature_reading (req_temperature_reading),
      .req_ph_reading          (req_ph_reading),
      .req_tds_reading         (req_tds_reading),
      .req_button_level        (req_button_level),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_temp_alert          (rsp_temp_alert),
      .rsp_ph_alert            (rsp_ph_alert),
      .rsp_tds_alert           (rsp_tds_alert),
      .rsp_button_out          (rsp_button_out),
      .rsp_temp_event          (rsp_temp_event),
      .rsp_ph_event            (rsp_ph_event),
      .rsp_tds_event           (rsp_tds_event),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // exact line test: 10000*d > icpt - slope*t
   function automatic bit above_line(longint d, longint t, longint slope, longint icpt);
      return d * LINE_SCALE > icpt - slope * t;
   endfunction

   // alarm decision for one sample, advances the alert history
   function automatic verdict_type grade_sample(sample_type s);
      longint      t, p, d;
      longint      lo_t, hi_t, lo_p, hi_p, band1_end, band3_end;
      logic        t_low, t_alert, p_low, p_alert, d_alert;
      verdict_type v;
      t = longint'($signed(s.temperature));
      p = longint'(s.ph);
      d = longint'(s.tds);
      lo_t = longint'($signed(limits.temp_low_limit));
      hi_t = longint'($signed(limits.temp_high_limit));
      lo_p = longint'(limits.ph_low_limit);
      hi_p = longint'(limits.ph_high_limit);
      band1_end = lo_p + longint'(limits.ph_band_width);
      band3_end = lo_p + 3 * longint'(limits.ph_band_width);

      t_low = t < lo_t;
      t_alert = t_low || t > hi_t;
      p_low = p < lo_p;
      p_alert = p_low || p > hi_p;
      d_alert = d > longint'(limits.tds_default_limit);

      // inside the temperature window a pH band line replaces the default limit
      if (!t_alert) begin
         if (p >= lo_p && p < band1_end)
            d_alert = above_line(d, t, SHALLOW_SLOPE, BAND_A_ICPT);
         if (p >= band1_end && p < band3_end)
            d_alert = above_line(d, t, STEEP_SLOPE, BAND_B_ICPT);
         if (p >= band3_end && p <= hi_p)
            d_alert = above_line(d, t, SHALLOW_SLOPE, BAND_C_ICPT);
      end

      v.temp_alert = t_alert;
      v.ph_alert = p_alert;
      v.tds_alert = d_alert;
      v.button_out = s.button;
      v.temp_event = (t_alert && !last_temp_alert) ? (t_low ? EV_LOW : EV_HIGH) : EV_NONE;
      v.ph_event = (p_alert && !last_ph_alert) ? (p_low ? EV_LOW : EV_HIGH) : EV_NONE;
      v.tds_event = d_alert && !last_tds_alert;

      last_temp_alert = t_alert;
      last_ph_alert = p_alert;
      last_tds_alert = d_alert;
      return v;
   endfunction

   function automatic string verdict_text(verdict_type v);
      return $sformatf("ta=%0b pa=%0b da=%0b btn=%0b tev=%0d pev=%0d dev=%0b",
                       v.temp_alert, v.ph_alert, v.tds_alert, v.button_out,
                       v.temp_event, v.ph_event, v.tds_event);
   endfunction

   task automatic report_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] %s", $realtime, msg);
   endtask

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 19);
      if (calm || r < 12)
         return 0;
      else if (r < 18)
         return $urandom_range(1, 3);
      else
         return $urandom_range(6, 30);
   endfunction

   // sample driver: offers queued samples, grades each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         last_temp_alert = 1'b0;
         last_ph_alert = 1'b0;
         last_tds_alert = 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_verdicts.push_back(grade_sample(offered));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (pending_samples.size() != 0) begin
               offered = pending_samples.pop_front();
               req_temperature_reading <= offered.temperature;
               req_ph_reading <= offered.ph;
               req_tds_reading <= offered.tds;
               req_button_level <= offered.button;
               req_valid <= 1'b1;
               send_gap = draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side back-pressure, including the long hold-off
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (hold_off_cycles > 0) begin
            stall_left = hold_off_cycles;
            hold_off_cycles = 0;
         end
         r = $urandom_range(0, 19);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (calm || r < 13) begin
            rsp_ready <= 1'b1;
         end else if (r < 19) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(8, 40);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_temp_alert, rsp_ph_alert, rsp_tds_alert, rsp_button_out,
                rsp_temp_event, rsp_ph_event, rsp_tds_event};
         if (expected_verdicts.size() == 0) begin
            report_failure($sformatf("result %0d with nothing expected: %s",
                                     result_count, verdict_text(got)));
         end else begin
            want = expected_verdicts.pop_front();
            if (got !== want)
               report_failure($sformatf("result %0d mismatch: expected %s, got %s",
                                        result_count, verdict_text(want), verdict_text(got)));
         end
         result_count++;
      end
   end

   // register write: setup then access cycle
   task automatic write_reg(reg_index_type idx, logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_TEMP_LOW:  limits.temp_low_limit = value[TEMP_W-1:0];
         REG_TEMP_HIGH: limits.temp_high_limit = value[TEMP_W-1:0];
         REG_PH_LOW:    limits.ph_low_limit = value[PH_W-1:0];
         REG_PH_HIGH:   limits.ph_high_limit = value[PH_W-1:0];
         REG_PH_BAND:   limits.ph_band_width = value[BAND_W-1:0];
         REG_TDS_DEF:   limits.tds_default_limit = value[TDS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_limits(int t_lo, int t_hi, int p_lo, int p_hi, int band, int tds_def);
      write_reg(REG_TEMP_LOW, t_lo & 32'h7fff);
      write_reg(REG_TEMP_HIGH, t_hi & 32'h7fff);
      write_reg(REG_PH_LOW, p_lo & 32'h7ff);
      write_reg(REG_PH_HIGH, p_hi & 32'h7ff);
      write_reg(REG_PH_BAND, band & 32'h1ff);
      write_reg(REG_TDS_DEF, tds_def & 32'hffff);
   endtask

   task automatic push_sample(int t, int p, int d, bit b);
      sample_type s;
      s.temperature = TEMP_W'(t);
      s.ph = PH_W'(p);
      s.tds = TDS_W'(d);
      s.button = b;
      pending_samples.push_back(s);
   endtask

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint pick_temperature();
      longint lo, hi;
      int     r;
      lo = longint'($signed(limits.temp_low_limit));
      hi = longint'($signed(limits.temp_high_limit));
      r = $urandom_range(0, 9);
      if (r < 6 && lo <= hi)
         return lo + longint'($urandom_range(0, int'(hi - lo)));
      else if (r < 8)
         return (r == 6 ? lo : hi) + longint'($urandom_range(0, 2)) - 1;
      else
         return longint'($urandom_range(0, 32767)) - 16384;
   endfunction

   function automatic longint pick_ph();
      longint lo, hi, w, mark;
      int     r;
      lo = longint'(limits.ph_low_limit);
      hi = longint'(limits.ph_high_limit);
      w = longint'(limits.ph_band_width);
      r = $urandom_range(0, 9);
      // band boundaries are where the interesting behavior sits
      if (r < 5) begin
         case ($urandom_range(0, 3))
            0: mark = lo;
            1: mark = lo + w;
            2: mark = lo + 3 * w;
            default: mark = hi;
         endcase
         return clamp(mark + longint'($urandom_range(0, 4)) - 2, 0, 2047);
      end else if (r < 8 && lo <= hi) begin
         return lo + longint'($urandom_range(0, int'(hi - lo)));
      end else begin
         return longint'($urandom_range(0, 2047));
      end
   endfunction

   function automatic longint pick_tds(longint t);
      longint near;
      int     r;
      r = $urandom_range(0, 9);
      // close to one of the band lines or to the default limit
      if (r < 5) begin
         case ($urandom_range(0, 2))
            0: near = (BAND_A_ICPT - SHALLOW_SLOPE * t) / LINE_SCALE;
            1: near = (BAND_B_ICPT - STEEP_SLOPE * t) / LINE_SCALE;
            default: near = (BAND_C_ICPT - SHALLOW_SLOPE * t) / LINE_SCALE;
         endcase
      end else if (r < 7) begin
         near = longint'(limits.tds_default_limit);
      end else begin
         return longint'($urandom_range(0, 65535));
      end
      return clamp(near + longint'($urandom_range(0, 6)) - 3, 0, 65535);
   endfunction

   task automatic random_batch(int count);
      longint t;
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         t = pick_temperature();
         push_sample(int'(t), int'(pick_ph()), int'(pick_tds(t)), $urandom_range(0, 1));
      end
   endtask

   // sender pause: everything sent and every result back
   task automatic wait_for_quiet();
      int waited;
      waited = 0;
      while ((pending_samples.size() != 0 || req_valid || expected_verdicts.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_verdicts.size() != 0) begin
         report_failure($sformatf("%0d results never arrived", expected_verdicts.size()));
         expected_verdicts.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // stimulus sequence
   initial begin
      int t_lo, t_hi, p_lo, p_hi;
      limits.temp_low_limit = TEMP_LOW_RST;
      limits.temp_high_limit = TEMP_HIGH_RST;
      limits.ph_low_limit = PH_LOW_RST;
      limits.ph_high_limit = PH_HIGH_RST;
      limits.ph_band_width = BAND_RST;
      limits.tds_default_limit = TDS_DEF_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset limits: each band, its edges, both alert directions, field extremes
      @(negedge clock);
      push_sample(1500, 650, 0, 0);
      push_sample(1500, 650, 1050, 1);
      push_sample(3000, 699, 65535, 0);
      push_sample(3000, 700, 1000, 1);
      push_sample(2000, 799, 400, 0);
      push_sample(2000, 800, 616, 1);
      push_sample(2000, 850, 617, 0);
      push_sample(2000, 851, 1001, 0);
      push_sample(2000, 649, 1000, 1);
      push_sample(1499, 700, 1001, 0);
      push_sample(3001, 700, 0, 1);
      push_sample(-16384, 0, 0, 0);
      push_sample(16383, 2047, 65535, 1);
      push_sample(2500, 750, 0, 0);
      wait_for_quiet();

      // back-pressure: receiver holds off while the sender keeps streaming
      calm = 1'b1;
      @(negedge clock);
      hold_off_cycles = HOLD_OFF_LONG;
      random_batch(150);
      wait_for_quiet();
      calm = 1'b0;

      // widest legal limits: exact line equality and a negative temperature limit
      set_limits(-5500, 12500, 0, 1400, 350, 65535);
      @(negedge clock);
      push_sample(0, 0, 1300, 0);
      push_sample(0, 0, 1301, 1);
      push_sample(10000, 0, 0, 0);
      push_sample(5000, 700, 0, 1);
      push_sample(-5500, 1400, 1866, 0);
      push_sample(-5500, 1400, 1867, 1);
      random_batch(150);
      wait_for_quiet();

      // zero band width leaves only the top band
      set_limits(1500, 3000, 650, 850, 0, 1000);
      @(negedge clock);
      push_sample(2000, 650, 617, 0);
      push_sample(2000, 649, 1001, 1);
      random_batch(100);
      wait_for_quiet();

      // crossed limits
      set_limits(12500, -5500, 1400, 0, 0, 0);
      random_batch(100);
      wait_for_quiet();

      // full bit patterns in every register
      set_limits(-16384, 16383, 0, 2047, 511, 65535);
      random_batch(100);
      wait_for_quiet();

      // random limit sets, one of them without idling
      for (int k = 0; k < 5; k++) begin
         t_lo = $urandom_range(0, 18000) - 5500;
         t_hi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 18000) - 5500
                                            : t_lo + $urandom_range(0, 12500 - t_lo);
         p_lo = $urandom_range(0, 1400);
         p_hi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1400)
                                            : p_lo + $urandom_range(0, 1400 - p_lo);
         set_limits(t_lo, t_hi, p_lo, p_hi, $urandom_range(0, 350), $urandom_range(0, 65535));
         calm = (k == 2);
         random_batch(100);
         wait_for_quiet();
      end
      calm = 1'b0;

      // back to the reset limits
      set_limits(1500, 3000, 650, 850, 50, 1000);
      random_batch(100);
      wait_for_quiet();

      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== water_quality_alarm_unit.f =====
rtl/wqa_pkg.sv
rtl/wqa_eval.sv
rtl/water_quality_alarm_unit.sv
tb/tb_top.sv
